### hdl/spectrum_peak_prominence_filter_macros.svh
// Assertion macros used by the peak filter datapath.
`ifndef SPECTRUM_PEAK_PROMINENCE_FILTER_MACROS_SVH
`define SPECTRUM_PEAK_PROMINENCE_FILTER_MACROS_SVH

// Condition implies consequence in the same cycle.
`define SPPF_ASSERT_IMP(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("sppf check failed");

// Condition implies consequence in the next cycle.
`define SPPF_ASSERT_NXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("sppf check failed");

`endif

### hdl/sppf_pkg.sv
// Package: types, constants and codes of the spectrum peak prominence filter.
package sppf_pkg;

   localparam int SPECTRUM_SIZE = 128;
   localparam int SAMPLE_WIDTH  = 24;
   localparam int MAX_PEAKS     = SPECTRUM_SIZE / 2;
   localparam int IDX_W         = $clog2(SPECTRUM_SIZE);
   localparam int CNT_W         = IDX_W + 1;
   localparam int PK_W          = $clog2(MAX_PEAKS);
   localparam int PCNT_W        = PK_W + 1;
   localparam int REG_W         = 24;
   localparam int CSR_IDX_W     = 1;

   localparam logic [CSR_IDX_W-1:0] CSR_MIN_HEIGHT     = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_PROMINENCE = 1'd1;

   typedef struct packed {
      logic signed [SAMPLE_WIDTH-1:0] sample_value;
      logic                           sample_last;
   } req_payload_type;

   typedef struct packed {
      logic                           found;
      logic [IDX_W-1:0]               peak_location;
      logic signed [SAMPLE_WIDTH-1:0] peak_height;
      logic                           result_last;
   } rsp_payload_type;

   typedef struct packed {
      logic [IDX_W-1:0]               loc;
      logic signed [SAMPLE_WIDTH-1:0] height;
   } peak_entry_type;

   typedef enum logic [4:0] {
      S_IDLE, S_FIND_RD, S_FIND_EV, S_P_RD, S_P_LOAD, S_L_RD, S_L_EV,
      S_R_INIT, S_R_RD, S_R_EV, S_ML_INIT, S_ML_RD, S_ML_EV,
      S_MR_INIT, S_MR_RD, S_MR_EV, S_DECIDE, S_NEXT, S_EMIT, S_FINAL
   } state_type;

   typedef enum logic [4:0] {
      OP_LOAD, OP_FIND_RD, OP_FIND_EV, OP_P_RD, OP_P_LOAD, OP_L_RD, OP_L_EV,
      OP_R_INIT, OP_R_RD, OP_R_EV, OP_ML_INIT, OP_ML_RD, OP_ML_EV,
      OP_MR_INIT, OP_MR_RD, OP_MR_EV, OP_DECIDE, OP_NEXT, OP_EMIT, OP_FINAL
   } op_type;

   typedef struct packed {
      op_type op;
   } cmd_type;

   typedef struct packed {
      logic last_acc;
      logic short_spec;
      logic find_done;
      logic p_end;
      logic k_zero;
      logic k_end;
      logic pk_hit;
      logic ml_end;
      logic mr_end;
      logic pass;
      logic emit_go;
      logic out_free;
   } status_type;

endpackage

### hdl/sppf_ctrl.sv
// Controller: sequences loading, peak search, prominence scans and result output.
module sppf_ctrl import sppf_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  status_type st,
   output cmd_type    cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:    if (st.last_acc) state_in = S_FIND_RD;
         S_FIND_RD: state_in = st.short_spec ? S_P_RD : S_FIND_EV;
         S_FIND_EV: state_in = st.find_done ? S_P_RD : S_FIND_RD;
         S_P_RD:    state_in = st.p_end ? S_FINAL : S_P_LOAD;
         S_P_LOAD:  state_in = S_L_RD;
         S_L_RD:    state_in = st.k_zero ? S_R_INIT : S_L_EV;
         S_L_EV:    state_in = st.pk_hit ? S_R_INIT : S_L_RD;
         S_R_INIT:  state_in = S_R_RD;
         S_R_RD:    state_in = st.k_end ? S_ML_INIT : S_R_EV;
         S_R_EV:    state_in = st.pk_hit ? S_ML_INIT : S_R_RD;
         S_ML_INIT: state_in = S_ML_RD;
         S_ML_RD:   state_in = st.ml_end ? S_MR_INIT : S_ML_EV;
         S_ML_EV:   state_in = S_ML_RD;
         S_MR_INIT: state_in = S_MR_RD;
         S_MR_RD:   state_in = st.mr_end ? S_DECIDE : S_MR_EV;
         S_MR_EV:   state_in = S_MR_RD;
         S_DECIDE:  state_in = st.pass ? S_EMIT : S_NEXT;
         S_NEXT:    state_in = S_P_RD;
         S_EMIT:    if (st.emit_go) state_in = S_P_RD;
         S_FINAL:   if (st.out_free) state_in = S_IDLE;
         default:   state_in = S_IDLE;
      endcase
   end

   always_comb begin
      unique case (state_ff)
         S_IDLE:    cmd.op = OP_LOAD;
         S_FIND_RD: cmd.op = OP_FIND_RD;
         S_FIND_EV: cmd.op = OP_FIND_EV;
         S_P_RD:    cmd.op = OP_P_RD;
         S_P_LOAD:  cmd.op = OP_P_LOAD;
         S_L_RD:    cmd.op = OP_L_RD;
         S_L_EV:    cmd.op = OP_L_EV;
         S_R_INIT:  cmd.op = OP_R_INIT;
         S_R_RD:    cmd.op = OP_R_RD;
         S_R_EV:    cmd.op = OP_R_EV;
         S_ML_INIT: cmd.op = OP_ML_INIT;
         S_ML_RD:   cmd.op = OP_ML_RD;
         S_ML_EV:   cmd.op = OP_ML_EV;
         S_MR_INIT: cmd.op = OP_MR_INIT;
         S_MR_RD:   cmd.op = OP_MR_RD;
         S_MR_EV:   cmd.op = OP_MR_EV;
         S_DECIDE:  cmd.op = OP_DECIDE;
         S_NEXT:    cmd.op = OP_NEXT;
         S_EMIT:    cmd.op = OP_EMIT;
         S_FINAL:   cmd.op = OP_FINAL;
         default:   cmd.op = OP_LOAD;
      endcase
   end

endmodule

### hdl/sppf_datapath.sv
// Datapath: sample and peak memories, scan counters, running minima and result register.
`include "spectrum_peak_prominence_filter_macros.svh"
module sppf_datapath import sppf_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  cmd_type               cmd,
   output status_type            st,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_payload_type       req_payload,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_payload_type       rsp_payload,
   input  logic                  csr_write_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [REG_W-1:0]      csr_wdata
);

   logic signed [SAMPLE_WIDTH-1:0] sample_mem [SPECTRUM_SIZE];
   peak_entry_type                 peak_mem   [MAX_PEAKS];

   logic signed [SAMPLE_WIDTH-1:0] s_rd_ff;
   peak_entry_type                 pk_rd_ff;

   logic signed [REG_W-1:0]        min_height_ff;
   logic [REG_W-1:0]               min_prom_ff;

   logic [CNT_W-1:0]               cnt_ff, n_ff, idx_ff, j_ff;
   logic [PCNT_W-1:0]              pcnt_ff, p_ff, k_ff;
   logic signed [SAMPLE_WIDTH-1:0] prev_ff, h_ff, minl_ff, minr_ff;
   logic [IDX_W-1:0]               cand_ff, loc_ff, lo_ff, hi_ff;
   logic                           cand_vld_ff;
   logic                           pend_vld_ff;
   logic [IDX_W-1:0]               pend_loc_ff;
   logic signed [SAMPLE_WIDTH-1:0] pend_h_ff;
   logic                           rsp_valid_ff;
   rsp_payload_type                rsp_data_ff;

   logic                           req_acc, s_we, pk_we, room, load_out;
   logic [IDX_W-1:0]               s_raddr;
   logic [PK_W-1:0]                pk_raddr;
   logic [PCNT_W-1:0]              km1;
   logic [CNT_W-1:0]               n_m1;
   logic signed [SAMPLE_WIDTH-1:0] max_min;
   logic [SAMPLE_WIDTH:0]          prom;
   rsp_payload_type                out_in;

   assign req_ready = (cmd.op == OP_LOAD);
   assign req_acc   = req_valid && req_ready;
   assign room      = (cnt_ff < CNT_W'(SPECTRUM_SIZE));
   assign s_we      = req_acc && room;
   assign km1       = k_ff - PCNT_W'(1);
   assign n_m1      = n_ff - CNT_W'(1);
   assign s_raddr   = (cmd.op == OP_FIND_RD) ? idx_ff[IDX_W-1:0] : j_ff[IDX_W-1:0];
   assign pk_raddr  = (cmd.op == OP_P_RD) ? p_ff[PK_W-1:0] :
                      (cmd.op == OP_L_RD) ? km1[PK_W-1:0] : k_ff[PK_W-1:0];

   // A falling step ends a rising run or plateau: record its first index.
   assign pk_we = (cmd.op == OP_FIND_EV) && (idx_ff != '0) && (s_rd_ff < prev_ff) &&
                  cand_vld_ff && (prev_ff >= min_height_ff) &&
                  (pcnt_ff != PCNT_W'(MAX_PEAKS));

   assign max_min = (minl_ff > minr_ff) ? minl_ff : minr_ff;
   assign prom    = {h_ff[SAMPLE_WIDTH-1], h_ff} - {max_min[SAMPLE_WIDTH-1], max_min};

   always_comb begin
      st.last_acc   = req_acc && req_payload.sample_last;
      st.short_spec = (n_ff < CNT_W'(3));
      st.find_done  = (idx_ff == n_m1);
      st.p_end      = (p_ff == pcnt_ff);
      st.k_zero     = (k_ff == '0);
      st.k_end      = (k_ff >= pcnt_ff);
      st.pk_hit     = (pk_rd_ff.height > h_ff);
      st.ml_end     = (j_ff >= {1'b0, loc_ff});
      st.mr_end     = (j_ff > {1'b0, hi_ff});
      st.pass       = (prom >= {1'b0, min_prom_ff});
      st.out_free   = !rsp_valid_ff || rsp_ready;
      st.emit_go    = !pend_vld_ff || st.out_free;
   end

   always_comb begin
      load_out = 1'b0;
      out_in   = '0;
      if (cmd.op == OP_EMIT && pend_vld_ff && st.out_free) begin
         load_out             = 1'b1;
         out_in.found         = 1'b1;
         out_in.peak_location = pend_loc_ff;
         out_in.peak_height   = pend_h_ff;
      end else if (cmd.op == OP_FINAL && st.out_free) begin
         load_out             = 1'b1;
         out_in.found         = pend_vld_ff;
         out_in.peak_location = pend_vld_ff ? pend_loc_ff : '0;
         out_in.peak_height   = pend_vld_ff ? pend_h_ff : '0;
         out_in.result_last   = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (s_we) begin
         sample_mem[cnt_ff[IDX_W-1:0]] <= req_payload.sample_value;
      end
      s_rd_ff <= sample_mem[s_raddr];
   end

   always_ff @(posedge clock) begin
      if (pk_we) begin
         peak_mem[pcnt_ff[PK_W-1:0]] <= '{loc: cand_ff, height: prev_ff};
      end
      pk_rd_ff <= peak_mem[pk_raddr];
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         min_height_ff <= {1'b1, {(REG_W-1){1'b0}}};
         min_prom_ff   <= '0;
         cnt_ff        <= '0;
         pcnt_ff       <= '0;
         pend_vld_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_write_en) begin
            unique case (csr_index)
               CSR_MIN_HEIGHT:     min_height_ff <= csr_wdata;
               CSR_MIN_PROMINENCE: min_prom_ff   <= csr_wdata;
               default: ;
            endcase
         end
         if (req_acc) begin
            if (req_payload.sample_last) begin
               cnt_ff  <= '0;
               pcnt_ff <= '0;
            end else if (room) begin
               cnt_ff <= cnt_ff + CNT_W'(1);
            end
         end
         if (pk_we) begin
            pcnt_ff <= pcnt_ff + PCNT_W'(1);
         end
         if (cmd.op == OP_EMIT && st.emit_go) begin
            pend_vld_ff <= 1'b1;
         end else if (cmd.op == OP_FINAL && st.out_free) begin
            pend_vld_ff <= 1'b0;
         end
         if (load_out) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      if (load_out) begin
         rsp_data_ff <= out_in;
      end
      case (cmd.op)
         OP_LOAD: begin
            if (st.last_acc) begin
               n_ff   <= room ? cnt_ff + CNT_W'(1) : cnt_ff;
               idx_ff <= '0;
               p_ff   <= '0;
            end
         end
         OP_FIND_EV: begin
            if (idx_ff == '0) begin
               cand_vld_ff <= 1'b0;
            end else if (s_rd_ff > prev_ff) begin
               cand_ff     <= idx_ff[IDX_W-1:0];
               cand_vld_ff <= 1'b1;
            end else if (s_rd_ff < prev_ff) begin
               cand_vld_ff <= 1'b0;
            end
            prev_ff <= s_rd_ff;
            idx_ff  <= idx_ff + CNT_W'(1);
         end
         OP_P_LOAD: begin
            loc_ff  <= pk_rd_ff.loc;
            h_ff    <= pk_rd_ff.height;
            minl_ff <= pk_rd_ff.height;
            minr_ff <= pk_rd_ff.height;
            lo_ff   <= '0;
            hi_ff   <= n_m1[IDX_W-1:0];
            k_ff    <= p_ff;
         end
         OP_L_EV: begin
            if (st.pk_hit) begin
               lo_ff <= pk_rd_ff.loc;
            end else begin
               k_ff <= km1;
            end
         end
         OP_R_INIT: k_ff <= p_ff + PCNT_W'(1);
         OP_R_EV: begin
            if (st.pk_hit) begin
               hi_ff <= pk_rd_ff.loc;
            end else begin
               k_ff <= k_ff + PCNT_W'(1);
            end
         end
         OP_ML_INIT: j_ff <= {1'b0, lo_ff};
         OP_ML_EV: begin
            if (s_rd_ff < minl_ff) begin
               minl_ff <= s_rd_ff;
            end
            j_ff <= j_ff + CNT_W'(1);
         end
         OP_MR_INIT: j_ff <= {1'b0, loc_ff} + CNT_W'(1);
         OP_MR_EV: begin
            if (s_rd_ff < minr_ff) begin
               minr_ff <= s_rd_ff;
            end
            j_ff <= j_ff + CNT_W'(1);
         end
         OP_NEXT: p_ff <= p_ff + PCNT_W'(1);
         OP_EMIT: begin
            if (st.emit_go) begin
               pend_loc_ff <= loc_ff;
               pend_h_ff   <= h_ff;
               p_ff        <= p_ff + PCNT_W'(1);
            end
         end
         default: ;
      endcase
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_data_ff;

   `SPPF_ASSERT_IMP(a_pcnt_bound, 1'b1, pcnt_ff <= PCNT_W'(MAX_PEAKS))
   `SPPF_ASSERT_NXT(a_final_last, cmd.op == OP_FINAL && st.out_free, rsp_valid_ff && rsp_data_ff.result_last)
   `SPPF_ASSERT_IMP(a_right_scan, cmd.op == OP_MR_EV, j_ff < n_ff)

endmodule

### hdl/spectrum_peak_prominence_filter.sv
// Top level: spectrum peak finder with height and prominence filtering.
// Samples load at one per cycle into a 128-entry sample memory until the request
// marked last; results follow in ascending location order, the final one flagged
// result_last, or one result with found low when no peak survives. After the last
// request the block is busy with a peak search over the n samples, then for each
// peak at or above min_height with a step through the peak list to its nearest
// higher neighbors and a step per sample between them, since the sample and peak
// memories each give one registered read per step; the worst case has n/2 peaks of
// equal height that each scan the whole peak list and the whole spectrum. New
// requests are taken again once the final result has entered the output register,
// while it still waits on rsp_ready.
module spectrum_peak_prominence_filter import sppf_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_payload_type       req_payload,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_payload_type       rsp_payload,
   input  logic                  csr_write_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [REG_W-1:0]      csr_wdata
);

   cmd_type    cmd;
   status_type st;

   sppf_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .st    (st),
      .cmd   (cmd)
   );

   sppf_datapath u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .st           (st),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_payload  (req_payload),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_payload  (rsp_payload),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

endmodule

### test/tb.sv
// Testbench for the spectrum peak prominence filter: scoreboard with its own peak predictor.
`timescale 1ns / 1ps

module tb import sppf_pkg::*; ;

   class peak_scoreboard;
      logic signed [SAMPLE_WIDTH-1:0] spectrum[SPECTRUM_SIZE];
      int unsigned                    n_loaded;
      logic signed [REG_W-1:0]        height_floor;
      logic [REG_W-1:0]               prominence_floor;
      rsp_payload_type                pending[$];
      int                             errors;

      function void clear();
         n_loaded = 0;
         height_floor = 24'sh800000;
         prominence_floor = '0;
         pending.delete();
         errors = 0;
      endfunction

      function void set_reg(logic [CSR_IDX_W-1:0] idx, logic [REG_W-1:0] val);
         if (idx == CSR_MIN_HEIGHT) height_floor = val;
         else prominence_floor = val;
      endfunction

      // Note one accepted request; on the last sample, predict the whole peak list.
      function void note_request(req_payload_type r);
         int unsigned n, i, j, np, p, k, lo, hi, emitted;
         int unsigned peaks[$];
         longint h, x, ml, mr, prom;
         rsp_payload_type e;
         if (n_loaded < SPECTRUM_SIZE) begin
            spectrum[n_loaded] = r.sample_value;
            n_loaded++;
         end
         if (!r.sample_last) return;
         n = n_loaded;
         n_loaded = 0;
         i = 1;
         while (i + 1 < n) begin
            x = longint'(spectrum[i]);
            if (spectrum[i-1] < x) begin
               if (spectrum[i+1] < x) begin
                  if (x >= height_floor && peaks.size() < MAX_PEAKS) peaks = {peaks, i};
               end else if (spectrum[i+1] == x) begin
                  j = i + 1;
                  while (j + 1 < n && spectrum[j+1] == x) j++;
                  if (j + 1 >= n) break;
                  if (spectrum[j+1] < x && x >= height_floor && peaks.size() < MAX_PEAKS)
                     peaks = {peaks, i};
                  i = j;
               end
            end
            i++;
         end
         np = peaks.size();
         emitted = 0;
         for (p = 0; p < np; p++) begin
            h = longint'(spectrum[peaks[p]]);
            lo = 0;
            hi = n - 1;
            ml = h;
            mr = h;
            for (k = p; k > 0; k--)
               if (spectrum[peaks[k-1]] > h) begin
                  lo = peaks[k-1];
                  break;
               end
            for (k = p + 1; k < np; k++)
               if (spectrum[peaks[k]] > h) begin
                  hi = peaks[k];
                  break;
               end
            for (j = lo; j < peaks[p]; j++)
               if (spectrum[j] < ml) ml = longint'(spectrum[j]);
            for (j = peaks[p] + 1; j <= hi && j < n; j++)
               if (spectrum[j] < mr) mr = longint'(spectrum[j]);
            prom = h - ((ml > mr) ? ml : mr);
            if (prom >= 0 && prom >= longint'(prominence_floor)) begin
               e.found = 1'b1;
               e.peak_location = IDX_W'(peaks[p]);
               e.peak_height = spectrum[peaks[p]];
               e.result_last = 1'b0;
               pending = {pending, e};
               emitted++;
            end
         end
         if (emitted == 0) begin
            e = '0;
            e.result_last = 1'b1;
            pending = {pending, e};
         end else begin
            pending[pending.size()-1].result_last = 1'b1;
         end
      endfunction

      function void check_result(rsp_payload_type got);
         rsp_payload_type want;
         if (pending.size() == 0) begin
            $display("%0t: unexpected result %h", $time, got);
            errors++;
            return;
         end
         want = pending.pop_front();
         if (got.found !== want.found)
            $display("%0t: found expected %0d actual %0d", $time, want.found, got.found);
         if (got.peak_location !== want.peak_location)
            $display("%0t: peak_location expected %0d actual %0d", $time,
                     want.peak_location, got.peak_location);
         if (got.peak_height !== want.peak_height)
            $display("%0t: peak_height expected %0d actual %0d", $time,
                     want.peak_height, got.peak_height);
         if (got.result_last !== want.result_last)
            $display("%0t: result_last expected %0d actual %0d", $time,
                     want.result_last, got.result_last);
         if (got !== want) errors++;
      endfunction
   endclass

   localparam int WATCHDOG_LIMIT = 200000;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   req_payload_type      req_payload = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   rsp_payload_type      rsp_payload;
   logic                 csr_write_en = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = CSR_MIN_HEIGHT;
   logic [REG_W-1:0]     csr_wdata = '0;

   peak_scoreboard sb = new();
   int  idle_cycles;
   bit  calm;
   bit  hold_rsp;

   spectrum_peak_prominence_filter dut (.*);

   always #2 clock = ~clock;

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   // Receiver: random stall bursts, plus one long hold-off on request.
   initial begin : receiver
      int gap;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready) sb.check_result(rsp_payload);
         if (hold_rsp) begin
            rsp_ready <= 1'b0;
            repeat (3000) @(posedge clock);
            hold_rsp = 1'b0;
            rsp_ready <= 1'b1;
         end else if (!calm && $urandom_range(0, 5) == 0) begin
            rsp_ready <= 1'b0;
            gap = $urandom_range(1, 13);
            repeat (gap) begin
               @(posedge clock);
            end
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // Hold valid after acceptance; the next request or an explicit drop replaces it.
   task automatic send_sample(logic signed [SAMPLE_WIDTH-1:0] v, bit last);
      req_payload_type r;
      r.sample_value = v;
      r.sample_last = last;
      if (!calm && $urandom_range(0, 6) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 13)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= r;
      do @(posedge clock); while (!req_ready);
      sb.note_request(r);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [REG_W-1:0] val);
      req_valid <= 1'b0;
      // drain outstanding results, then let the block settle before changing thresholds
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      csr_write_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_write_en <= 1'b0;
      sb.set_reg(idx, val);
   endtask

   function automatic logic signed [SAMPLE_WIDTH-1:0] rand_sample(int mode);
      case (mode)
         0: return SAMPLE_WIDTH'(int'($urandom_range(0, 15)) - 8);
         1: return SAMPLE_WIDTH'(int'($urandom_range(0, 2000)) - 1000);
         default: return SAMPLE_WIDTH'($urandom);
      endcase
   endfunction

   task automatic send_spectrum(int len, int mode);
      for (int i = 0; i < len; i++) send_sample(rand_sample(mode), i == len - 1);
   endtask

   initial begin : driver
      int sent;
      sb.clear();
      calm = 0;
      hold_rsp = 0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // directed: single peak, extremes, plateau, plateau at end, short, overflow
      send_sample(24'sh800000, 0); send_sample(24'sh7fffff, 0); send_sample(24'sh800000, 1);
      send_sample(0, 0); send_sample(5, 0); send_sample(5, 0); send_sample(1, 1);
      send_sample(0, 0); send_sample(5, 0); send_sample(5, 1);
      send_sample(3, 0); send_sample(9, 1);
      send_sample(7, 1);
      send_spectrum(131, 2);
      write_reg(CSR_MIN_HEIGHT, 24'h7fffff);
      write_reg(CSR_MIN_PROMINENCE, 24'hffffff);
      send_sample(0, 0); send_sample(24'sh7fffff, 0); send_sample(0, 1);
      write_reg(CSR_MIN_HEIGHT, 24'h000000);
      write_reg(CSR_MIN_PROMINENCE, 24'd4);
      sent = 150;
      // fill the output path while the receiver holds off
      hold_rsp = 1;
      send_spectrum(6, 0);
      send_spectrum(6, 0);
      send_spectrum(6, 0);
      while (sent < 460) begin
         int len, mode;
         if (sent > 380 && !calm) begin
            write_reg(CSR_MIN_HEIGHT, 24'h800000);
            write_reg(CSR_MIN_PROMINENCE, 24'd0);
            calm = 1;
         end
         if (sent > 250 && sent < 270) begin
            write_reg(CSR_MIN_HEIGHT, REG_W'(int'($urandom_range(0, 1500)) - 750));
            write_reg(CSR_MIN_PROMINENCE, REG_W'($urandom_range(0, 300)));
         end
         len = ($urandom_range(0, 15) == 0) ? $urandom_range(100, 130) : $urandom_range(1, 24);
         mode = $urandom_range(0, 2);
         send_spectrum(len, mode);
         sent += len;
      end
      req_valid <= 1'b0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (sb.errors == 0 && sb.pending.size() == 0) $display("== PASS ==");
      else $display("== FAIL ==");
      $finish;
   end
endmodule
